[hdl/bgl_pkg.sv]
// Shared constants, types and sequencer codes for the binary gcd/lcm unit.
`default_nettype none

package bgl_pkg;

    localparam int OPERAND_BITS = 63;
    localparam int SHIFT_W      = $clog2(OPERAND_BITS);
    localparam int S_TDATA_W    = ((2 * OPERAND_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((2 * OPERAND_BITS + 7) / 8) * 8;

    typedef logic [OPERAND_BITS-1:0] opnd_t;
    typedef logic [SHIFT_W-1:0]      shift_t;

    typedef struct packed {
        logic  start;
        opnd_t a;
        opnd_t b;
    } bgl_req_t;

    typedef struct packed {
        logic  idle;
        logic  done;
        opnd_t gcd;
        opnd_t lcm;
        logic  ovf;
    } bgl_rsp_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GCD   = 6'b000010,
        S_SHIFT = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_DONE  = 6'b100000
    } bgl_state_t;

endpackage

`default_nettype wire

[hdl/binary_gcd_lcm_unit.sv]
// Top level: stream ports and output register around the gcd/lcm engine.
//
//  channel | dir | fields (low bit up)                    | beat
//  s_axis  | in  | tdata: operand_a, operand_b            | one operand pair
//  m_axis  | out | tdata: gcd_value, lcm_value; tuser: lcm_overflow | one result
//
// Steps: up to 2*OPERAND_BITS gcd rounds (one compare-subtract-shift each),
// one shift step, OPERAND_BITS divide steps, OPERAND_BITS multiply steps and
// one done step; a zero operand goes straight from idle to the done step.
// Reset: aresetn synchronous, active low; clears sequencer and output valid.
// Stalls: s_axis_tready is low while an item is in work or a result waits.
`default_nettype none

module binary_gcd_lcm_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bgl_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // operand_a, operand_b
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bgl_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // gcd_value, lcm_value
    output logic                            m_axis_tuser   // lcm_overflow
);
    import bgl_pkg::*;

    localparam int W = OPERAND_BITS;

    bgl_req_t req;
    bgl_rsp_t rsp;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    bgl_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign s_axis_tready = rsp.idle & ~m_valid_reg;
    assign req.start     = s_axis_tvalid & s_axis_tready;
    assign req.a         = s_axis_tdata[W-1:0];
    assign req.b         = s_axis_tdata[2*W-1:W];

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (rsp.done) begin
            m_valid_next            = 1'b1;
            m_data_next             = '0;
            m_data_next[W-1:0]      = rsp.gcd;
            m_data_next[2*W-1:W]    = rsp.lcm;
            m_user_next             = rsp.ovf;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

[hdl/bgl_engine.sv]
// Sequenced datapath: binary gcd, restoring divide a/gcd, shift-add multiply by b.
`default_nettype none

module bgl_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  bgl_pkg::bgl_req_t  req,
    output bgl_pkg::bgl_rsp_t  rsp
);
    import bgl_pkg::*;

    localparam int     W        = OPERAND_BITS;
    localparam shift_t CNT_LAST = shift_t'(OPERAND_BITS - 1);

    bgl_state_t state_reg, state_next;
    opnd_t      a_reg, a_next;
    opnd_t      b_reg, b_next;
    opnd_t      u_reg, u_next;
    opnd_t      v_reg, v_next;
    opnd_t      g_reg, g_next;
    opnd_t      r_reg, r_next;
    opnd_t      n_reg, n_next;
    opnd_t      acc_reg, acc_next;
    shift_t     k_reg, k_next;
    shift_t     cnt_reg, cnt_next;
    logic       ovf_reg, ovf_next;

    logic           u_gt_v;
    opnd_t          big, lit, diff;
    logic [W:0]     rem_sh, rem_sub;
    logic           rem_ge;
    logic [W+1:0]   mul_sum;
    opnd_t          addend;
    logic           last;

    always_comb begin
        u_gt_v  = u_reg > v_reg;
        big     = u_gt_v ? u_reg : v_reg;
        lit     = u_gt_v ? v_reg : u_reg;
        diff    = big - lit;
        rem_sh  = {r_reg, n_reg[W-1]};
        rem_ge  = rem_sh >= {1'b0, g_reg};
        rem_sub = rem_sh - {1'b0, g_reg};
        addend  = n_reg[W-1] ? b_reg : '0;
        mul_sum = {1'b0, acc_reg, 1'b0} + {2'b00, addend};
        last    = cnt_reg == CNT_LAST;
    end

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        g_next     = g_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    a_next   = req.a;
                    b_next   = req.b;
                    u_next   = req.a;
                    v_next   = req.b;
                    k_next   = '0;
                    acc_next = '0;
                    ovf_next = 1'b0;
                    if (req.a == '0 || req.b == '0) begin
                        g_next     = req.a | req.b;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (u_reg == v_reg) begin
                    state_next = S_SHIFT;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (u_gt_v) begin
                    u_next = diff >> 1;
                end else begin
                    v_next = diff >> 1;
                end
            end
            S_SHIFT: begin
                g_next     = u_reg << k_reg;
                r_next     = '0;
                n_next     = a_reg;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                r_next   = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                n_next   = {n_reg[W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (last) begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                acc_next = mul_sum[W-1:0];
                if (mul_sum[W+1:W] != 2'b00) begin
                    ovf_next = 1'b1;
                end
                n_next   = {n_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        g_reg   <= g_next;
        r_reg   <= r_next;
        n_reg   <= n_next;
        acc_reg <= acc_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.idle = state_reg == S_IDLE;
    assign rsp.done = state_reg == S_DONE;
    assign rsp.gcd  = g_reg;
    assign rsp.lcm  = ovf_reg ? {W{1'b1}} : acc_reg;
    assign rsp.ovf  = ovf_reg;

    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_GCD |-> (u_reg != '0 && v_reg != '0))
        else $error("gcd operand reached zero");

    a_rem_below_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> r_reg < g_reg)
        else $error("divide remainder not below gcd");

    a_div_count_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && $past(state_reg) == S_SHIFT) |-> cnt_reg == '0)
        else $error("divide step count not cleared");

    a_done_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |=> state_reg == S_IDLE)
        else $error("sequencer stuck after done");

endmodule

`default_nettype wire

[test/binary_gcd_lcm_unit_tb.sv]
// Self-checking stream testbench for the binary gcd/lcm unit with a behavioral predictor.
`timescale 1ns / 1ps

module binary_gcd_lcm_unit_tb;
    import bgl_pkg::*;

    localparam int RANDOM_PAIRS   = 1450;
    localparam int LONG_HOLD_AT   = 400;
    localparam int LONG_HOLD_LEN  = 600;
    localparam int DRAIN_AT       = 900;
    localparam int SETTLE_CYCLES  = 300;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        opnd_t a;
        opnd_t b;
    } pair_t;

    typedef struct packed {
        opnd_t gcd;
        opnd_t lcm;
        logic  ovf;
    } gcd_lcm_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;    // operand_a, operand_b
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;          // gcd_value, lcm_value
    logic                  m_axis_tuser;          // lcm_overflow

    pair_t    pending_pairs[$];
    gcd_lcm_t expected_results[$];

    int       errors         = 0;
    int       sent_count     = 0;
    int       recv_count     = 0;
    int       directed_count = 0;
    int       gap_left       = 0;
    int       hold_left      = 0;
    bit       long_hold_done = 1'b0;
    bit       in_beat        = 1'b0;
    pair_t    taken_pair;
    gcd_lcm_t want;

    binary_gcd_lcm_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int tz_of(logic [63:0] v);
        for (int i = 0; i < 64; i++) begin
            if (v[i]) return i;
        end
        return 0;
    endfunction

    // Stein's method on 64-bit working values, then lcm as (a / gcd) * b with saturation
    function automatic gcd_lcm_t gcd_lcm_of(opnd_t a, opnd_t b);
        logic [63:0] x, y, t, g, q, top;
        int          shared_tz;
        gcd_lcm_t    r;
        x   = {1'b0, a};
        y   = {1'b0, b};
        top = {1'b0, {OPERAND_BITS{1'b1}}};
        if (x == 0 || y == 0) begin
            g = x | y;
        end else begin
            shared_tz = tz_of(x | y);
            x = x >> tz_of(x);
            while (y != 0) begin
                y = y >> tz_of(y);
                if (x > y) begin
                    t = x;
                    x = y;
                    y = t;
                end
                y = y - x;
            end
            g = x << shared_tz;
        end
        r.gcd = g[OPERAND_BITS-1:0];
        r.lcm = '0;
        r.ovf = 1'b0;
        if (a != 0 && b != 0) begin
            q = {1'b0, a} / g;
            if (q > top / {1'b0, b}) begin
                r.lcm = '1;
                r.ovf = 1'b1;
            end else begin
                t     = q * {1'b0, b};
                r.lcm = t[OPERAND_BITS-1:0];
            end
        end
        return r;
    endfunction

    function automatic opnd_t rand_opnd();
        return opnd_t'({$urandom(), $urandom()});
    endfunction

    // random value of at most w bits
    function automatic opnd_t rand_bits(int w);
        return rand_opnd() >> (OPERAND_BITS - w);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 98) return $urandom_range(5, 40);
        return $urandom_range(100, 300);
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int    r, wg;
        opnd_t g;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            p.a = rand_opnd() >> (($urandom_range(0, 3) == 0) ? $urandom_range(0, 62) : 0);
            p.b = rand_opnd() >> (($urandom_range(0, 3) == 0) ? $urandom_range(0, 62) : 0);
        end else if (r < 55) begin
            wg  = $urandom_range(1, 40);
            g   = rand_bits(wg);
            p.a = g * rand_bits($urandom_range(1, OPERAND_BITS - wg));
            p.b = g * rand_bits($urandom_range(1, OPERAND_BITS - wg));
        end else if (r < 70) begin
            p.a = rand_opnd() << $urandom_range(0, 62);
            p.b = rand_opnd() << $urandom_range(0, 62);
        end else if (r < 78) begin
            p.a = rand_opnd() >> $urandom_range(0, 62);
            p.b = '0;
            if ($urandom_range(0, 1) == 1) p = '{p.b, p.a};
        end else if (r < 85) begin
            p.b = rand_bits($urandom_range(1, 40));
            p.a = ($urandom_range(0, 1) == 1) ? p.b : p.b * rand_bits($urandom_range(1, 20));
        end else if (r < 93) begin
            p.a = opnd_t'($urandom_range(0, 255));
            p.b = opnd_t'($urandom_range(0, 255));
        end else begin
            p.a = rand_opnd() >> $urandom_range(0, 31);
            p.b = rand_opnd() >> $urandom_range(0, 31);
        end
        return p;
    endfunction

    task automatic queue_pair(input pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, what);
    endtask

    // sender: holds an offered beat until taken, then waits a random gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !in_beat)) begin
            if (in_beat) gap_left = ((sent_count / 250) % 4 == 1) ? 0 : pick_gap();
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pairs.size() != 0
                         && !((sent_count == directed_count || sent_count == DRAIN_AT)
                              && expected_results.size() != 0)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= S_TDATA_W'({pending_pairs[0].b, pending_pairs[0].a});
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (recv_count == LONG_HOLD_AT && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_LEN;
            end else if (hold_left == 0 && (recv_count / 250) % 4 != 2
                         && $urandom_range(0, 7) == 0) begin
                hold_left = pick_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // input capture and result check
    always @(posedge aclk) begin
        in_beat = aresetn && s_axis_tvalid && s_axis_tready;
        if (in_beat) begin
            taken_pair.a = s_axis_tdata[OPERAND_BITS-1:0];
            taken_pair.b = s_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
            void'(pending_pairs.pop_front());
            expected_results.insert(expected_results.size(),
                                    gcd_lcm_of(taken_pair.a, taken_pair.b));
            sent_count++;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            recv_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[OPERAND_BITS-1:0] !== want.gcd)
                    report_mismatch($sformatf("beat %0d gcd %0d, want %0d", recv_count,
                                              m_axis_tdata[OPERAND_BITS-1:0], want.gcd));
                if (m_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS] !== want.lcm)
                    report_mismatch($sformatf("beat %0d lcm %0d, want %0d", recv_count,
                                              m_axis_tdata[2*OPERAND_BITS-1:OPERAND_BITS],
                                              want.lcm));
                if (m_axis_tuser !== want.ovf)
                    report_mismatch($sformatf("beat %0d overflow %b, want %b", recv_count,
                                              m_axis_tuser, want.ovf));
            end
        end
    end

    initial begin
        opnd_t top, one;
        top = '1;
        one = opnd_t'(1);
        queue_pair('{'0, '0});
        queue_pair('{'0, top});
        queue_pair('{top, '0});
        queue_pair('{one, '0});
        queue_pair('{'0, one});
        queue_pair('{one, one});
        queue_pair('{top, top});
        queue_pair('{top, one});
        queue_pair('{one, top});
        queue_pair('{top, opnd_t'(7)});
        queue_pair('{top, top - 1});
        queue_pair('{top - 1, opnd_t'(2)});
        queue_pair('{one << 62, one});
        queue_pair('{one << 62, opnd_t'(3)});
        queue_pair('{one << 62, one << 61});
        queue_pair('{one << 62, one << 62});
        queue_pair('{one << 32, (one << 31) + 1});
        queue_pair('{opnd_t'(6), opnd_t'(4)});
        queue_pair('{opnd_t'(12), opnd_t'(18)});
        queue_pair('{opnd_t'(3), opnd_t'(5)});
        queue_pair('{opnd_t'({32{2'b01}}), opnd_t'({32{2'b10}})});
        queue_pair('{opnd_t'({32{2'b10}}), opnd_t'({32{2'b01}})});
        directed_count = pending_pairs.size();
        repeat (RANDOM_PAIRS) queue_pair(rand_pair());

        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (pending_pairs.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("binary_gcd_lcm_unit: match");
        end else begin
            $display("binary_gcd_lcm_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("binary_gcd_lcm_unit: mismatch");
        $finish;
    end

endmodule
